>>> hw/rtl/c8rf_pkg.sv
// shared types and constants for the chip8 register and flow unit
// operation codes, field widths, reset values and the structs between the submodules
// no dependencies
package c8rf_pkg;

    localparam int CMD_W   = 5;
    localparam int REG_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 12;
    localparam int KEY_W   = 16;
    localparam int REG_CNT = 16;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;
    localparam logic [REG_W-1:0]  REG_F    = 4'hF;
    localparam logic [REG_W-1:0]  REG_V0   = 4'h0;

    localparam int STACK_DEPTH_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_RET      = 5'd0,
        CMD_JP       = 5'd1,
        CMD_CALL     = 5'd2,
        CMD_SE_IMM   = 5'd3,
        CMD_SNE_IMM  = 5'd4,
        CMD_SE_REG   = 5'd5,
        CMD_SNE_REG  = 5'd6,
        CMD_LD_IMM   = 5'd7,
        CMD_ADD_IMM  = 5'd8,
        CMD_LD_REG   = 5'd9,
        CMD_OR       = 5'd10,
        CMD_AND      = 5'd11,
        CMD_XOR      = 5'd12,
        CMD_ADD_REG  = 5'd13,
        CMD_SUB      = 5'd14,
        CMD_SHR      = 5'd15,
        CMD_SUBN     = 5'd16,
        CMD_SHL      = 5'd17,
        CMD_LD_INDEX = 5'd18,
        CMD_JP_V0    = 5'd19,
        CMD_SKP      = 5'd20,
        CMD_SKNP     = 5'd21
    } cmd_t;

    // register file write for one executed operation
    typedef struct packed {
        logic              wr_x;
        logic [REG_W-1:0]  x;
        logic [BYTE_W-1:0] result;
        logic [BYTE_W-1:0] f_next;
    } rf_wr_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_op_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [ADDR_W-1:0] top;
    } stk_stat_t;

endpackage

>>> hw/rtl/c8rf_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module c8rf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/c8rf_regs.sv
// data register file: two ram copies for the x and y read ports, valid bits for reset,
// dedicated flops for v0 and vf, forwarding of a write that lands on the read edge
// depends on c8rf_pkg and c8rf_ram
module c8rf_regs
    import c8rf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [REG_W-1:0]  rd_x,
    input  logic [REG_W-1:0]  rd_y,
    input  logic [REG_W-1:0]  ex_y,
    input  logic              wr_en,
    input  rf_wr_t            wr,
    output logic [BYTE_W-1:0] vx,
    output logic [BYTE_W-1:0] vy,
    output logic [BYTE_W-1:0] v0,
    output logic [BYTE_W-1:0] vf
);

    logic [REG_CNT-1:0] valid_reg;
    logic [BYTE_W-1:0]  v0_reg;
    logic [BYTE_W-1:0]  vf_reg;
    logic               x_ovr_reg;
    logic               y_ovr_reg;
    logic [BYTE_W-1:0]  x_ovr_data_reg;
    logic [BYTE_W-1:0]  y_ovr_data_reg;
    logic [BYTE_W-1:0]  x_rdata;
    logic [BYTE_W-1:0]  y_rdata;
    logic               ram_we;
    logic               hit_x;
    logic               hit_y;
    logic [BYTE_W-1:0]  vx_ram;
    logic [BYTE_W-1:0]  vy_ram;

    // register f lives only in vf_reg
    assign ram_we = wr_en && wr.wr_x && (wr.x != REG_F);
    assign hit_x  = ram_we && (wr.x == rd_x);
    assign hit_y  = ram_we && (wr.x == rd_y);

    c8rf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (REG_CNT)
    ) u_ram_x (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr.x),
        .wdata (wr.result),
        .re    (rd_en),
        .raddr (rd_x),
        .rdata (x_rdata)
    );

    c8rf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (REG_CNT)
    ) u_ram_y (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr.x),
        .wdata (wr.result),
        .re    (rd_en),
        .raddr (rd_y),
        .rdata (y_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            v0_reg    <= '0;
            vf_reg    <= '0;
        end
        else
        begin
            if (ram_we)
            begin
                valid_reg[wr.x] <= 1'b1;
            end
            if (ram_we && (wr.x == REG_V0))
            begin
                v0_reg <= wr.result;
            end
            if (wr_en)
            begin
                vf_reg <= wr.f_next;
            end
        end
    end

    // never written entries read as zero, a same-edge write wins over the ram
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            x_ovr_reg      <= hit_x || !valid_reg[rd_x];
            x_ovr_data_reg <= hit_x ? wr.result : '0;
            y_ovr_reg      <= hit_y || !valid_reg[rd_y];
            y_ovr_data_reg <= hit_y ? wr.result : '0;
        end
    end

    assign vx_ram = x_ovr_reg ? x_ovr_data_reg : x_rdata;
    assign vy_ram = y_ovr_reg ? y_ovr_data_reg : y_rdata;

    assign vx = (wr.x == REG_F) ? vf_reg : vx_ram;
    assign vy = (ex_y == REG_F) ? vf_reg : vy_ram;
    assign v0 = v0_reg;
    assign vf = vf_reg;

endmodule

>>> hw/rtl/c8rf_stack.sv
// return stack: top entry in a register, the rest in a ram whose read port always
// points at the entry below the top, with a bypass for a push on the read edge
// depends on c8rf_pkg and c8rf_ram
module c8rf_stack
    import c8rf_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  stk_op_t           op,
    input  logic [ADDR_W-1:0] push_data,
    output stk_stat_t         stat
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [DW-1:0]     depth_reg;
    logic [DW-1:0]     depth_next;
    logic [ADDR_W-1:0] top_reg;
    logic              byp_reg;
    logic [ADDR_W-1:0] byp_data_reg;
    logic              push;
    logic              pop;
    logic              we;
    logic [DW-1:0]     wr_ptr;
    logic [DW-1:0]     rd_ptr;
    logic [ADDR_W-1:0] rdata;
    logic [ADDR_W-1:0] second;

    assign push = en && op.push;
    assign pop  = en && op.pop;

    always_comb
    begin
        depth_next = depth_reg;
        if (push)
        begin
            depth_next = depth_reg + DW'(1);
        end
        else if (pop)
        begin
            depth_next = depth_reg - DW'(1);
        end
    end

    // a push spills the old top to entry depth-1, which is also the next read address
    assign we     = push && (depth_reg != '0);
    assign wr_ptr = depth_reg - DW'(1);
    assign rd_ptr = depth_next - DW'(2);

    c8rf_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wr_ptr[AW-1:0]),
        .wdata (top_reg),
        .re    (1'b1),
        .raddr (rd_ptr[AW-1:0]),
        .rdata (rdata)
    );

    assign second = byp_reg ? byp_data_reg : rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            byp_reg   <= we;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= top_reg;
        if (push)
        begin
            top_reg <= push_data;
        end
        else if (pop)
        begin
            top_reg <= second;
        end
    end

    assign stat.empty = (depth_reg == '0);
    assign stat.full  = (depth_reg == DW'(STACK_DEPTH));
    assign stat.top   = top_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("stack push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("stack pop while empty");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth out of range");

    a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (top_reg == $past(push_data)))
        else $error("pushed address not on top");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        en |-> !(op.push && op.pop))
        else $error("push and pop together");

endmodule

>>> hw/rtl/c8rf_alu.sv
// execute logic for one operation: register result and flag, next pc, index,
// stack request and fault
// depends on c8rf_pkg
module c8rf_alu
    import c8rf_pkg::*;
(
    input  cmd_t              cmd,
    input  logic [REG_W-1:0]  x,
    input  logic [BYTE_W-1:0] immediate,
    input  logic [ADDR_W-1:0] target_address,
    input  logic [KEY_W-1:0]  key_mask,
    input  logic [BYTE_W-1:0] vx,
    input  logic [BYTE_W-1:0] vy,
    input  logic [BYTE_W-1:0] v0,
    input  logic [BYTE_W-1:0] vf,
    input  logic [ADDR_W-1:0] pc,
    input  logic [ADDR_W-1:0] index_value,
    input  stk_stat_t         stk,
    output rf_wr_t            wr,
    output stk_op_t           stk_op,
    output logic [ADDR_W-1:0] pc_next,
    output logic [ADDR_W-1:0] index_next,
    output logic [BYTE_W-1:0] x_after,
    output logic              stack_fault
);

    logic [BYTE_W:0]   sum;
    logic              key_down;
    logic              wr_flag;
    logic              flag;
    logic              wr_x;
    logic [BYTE_W-1:0] result;
    logic [ADDR_W-1:0] pc_skip;

    assign sum      = {1'b0, vx} + {1'b0, vy};
    assign key_down = (vx[BYTE_W-1:REG_W] == '0) && key_mask[vx[REG_W-1:0]];
    assign pc_skip  = pc + ADDR_W'(2);

    always_comb
    begin
        wr_x        = 1'b0;
        wr_flag     = 1'b0;
        flag        = 1'b0;
        result      = '0;
        pc_next     = pc;
        index_next  = index_value;
        stk_op      = '0;
        stack_fault = 1'b0;
        case (cmd)
            CMD_RET:
            begin
                if (stk.empty)
                begin
                    stack_fault = 1'b1;
                end
                else
                begin
                    stk_op.pop = 1'b1;
                    pc_next    = stk.top;
                end
            end
            CMD_JP:
            begin
                pc_next = target_address;
            end
            CMD_CALL:
            begin
                if (stk.full)
                begin
                    stack_fault = 1'b1;
                end
                else
                begin
                    stk_op.push = 1'b1;
                    pc_next     = target_address;
                end
            end
            CMD_SE_IMM:
            begin
                if (vx == immediate)
                begin
                    pc_next = pc_skip;
                end
            end
            CMD_SNE_IMM:
            begin
                if (vx != immediate)
                begin
                    pc_next = pc_skip;
                end
            end
            CMD_SE_REG:
            begin
                if (vx == vy)
                begin
                    pc_next = pc_skip;
                end
            end
            CMD_SNE_REG:
            begin
                if (vx != vy)
                begin
                    pc_next = pc_skip;
                end
            end
            CMD_LD_IMM:
            begin
                wr_x   = 1'b1;
                result = immediate;
            end
            CMD_ADD_IMM:
            begin
                wr_x   = 1'b1;
                result = vx + immediate;
            end
            CMD_LD_REG:
            begin
                wr_x   = 1'b1;
                result = vy;
            end
            CMD_OR:
            begin
                wr_x   = 1'b1;
                result = vx | vy;
            end
            CMD_AND:
            begin
                wr_x   = 1'b1;
                result = vx & vy;
            end
            CMD_XOR:
            begin
                wr_x   = 1'b1;
                result = vx ^ vy;
            end
            CMD_ADD_REG:
            begin
                wr_x    = 1'b1;
                wr_flag = 1'b1;
                flag    = sum[BYTE_W];
                result  = sum[BYTE_W-1:0];
            end
            CMD_SUB:
            begin
                wr_x    = 1'b1;
                wr_flag = 1'b1;
                flag    = (vx > vy);
                result  = vx - vy;
            end
            CMD_SHR:
            begin
                wr_x    = 1'b1;
                wr_flag = 1'b1;
                flag    = vx[0];
                result  = {1'b0, vx[BYTE_W-1:1]};
            end
            CMD_SUBN:
            begin
                wr_x    = 1'b1;
                wr_flag = 1'b1;
                flag    = (vy > vx);
                result  = vy - vx;
            end
            CMD_SHL:
            begin
                wr_x    = 1'b1;
                wr_flag = 1'b1;
                flag    = vx[BYTE_W-1];
                result  = {vx[BYTE_W-2:0], 1'b0};
            end
            CMD_LD_INDEX:
            begin
                index_next = target_address;
            end
            CMD_JP_V0:
            begin
                pc_next = {{(ADDR_W-BYTE_W){1'b0}}, v0} + target_address;
            end
            CMD_SKP:
            begin
                if (key_down)
                begin
                    pc_next = pc_skip;
                end
            end
            CMD_SKNP:
            begin
                if (!key_down)
                begin
                    pc_next = pc_skip;
                end
            end
            default:
            begin
            end
        endcase
    end

    // flag is written first, so a result aimed at register f overrides it
    assign wr.wr_x   = wr_x;
    assign wr.x      = x;
    assign wr.result = result;
    assign wr.f_next = (wr_x && (x == REG_F)) ? result :
                       (wr_flag ? {{(BYTE_W-1){1'b0}}, flag} : vf);

    assign x_after = (x == REG_F) ? wr.f_next : (wr_x ? result : vx);

endmodule

>>> hw/rtl/chip8_register_and_flow_unit.sv
// top level of the chip8 register and flow unit: stream ports, input and result
// registers, program counter, index register and the execute submodules
// depends on c8rf_pkg, c8rf_regs, c8rf_stack, c8rf_alu (and c8rf_ram below them)

// Executes one decoded CHIP-8 operation per beat and returns the program counter,
// index register, register x, register f and a stack fault flag as they stand after
// it. One operation is taken every clock cycle while the output is not stalled; an
// accepted beat lands in the input register, and the edge on which it fires executes
// it into the result register, which presents the result.
// That rate is set by the execute loop: register file read, one ALU step and the
// write back all close between consecutive firing edges, with writes forwarded to the next
// operation's register file read. Data registers reset to zero through per-register
// valid bits; return stack entries are not cleared and no clearing pass is needed.
// A write on cfg_wr_en loads the program counter and must only be issued while no
// beat is in flight.
module chip8_register_and_flow_unit
    import c8rf_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cmd[4:0], reg_x[8:5], reg_y[12:9], immediate[20:13], target_address[32:21],
    // key_mask[48:33], zero[55:49]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // next_pc[11:0], index_value[23:12], x_value[31:24], flag_value[39:32],
    // stack_fault[40], zero[47:41]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_wr_en,
    input  logic [ADDR_W-1:0]     cfg_wr_data
);

    logic              accept;
    logic              fire;

    logic              in_vld_reg;
    logic [CMD_W-1:0]  in_cmd_reg;
    logic [REG_W-1:0]  in_x_reg;
    logic [REG_W-1:0]  in_y_reg;
    logic [BYTE_W-1:0] in_imm_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [KEY_W-1:0]  in_keys_reg;

    logic [ADDR_W-1:0] pc_reg;
    logic [ADDR_W-1:0] index_reg;

    logic              out_vld_reg;
    logic [ADDR_W-1:0] out_pc_reg;
    logic [ADDR_W-1:0] out_index_reg;
    logic [BYTE_W-1:0] out_x_reg;
    logic [BYTE_W-1:0] out_f_reg;
    logic              out_fault_reg;

    logic [BYTE_W-1:0] vx;
    logic [BYTE_W-1:0] vy;
    logic [BYTE_W-1:0] v0;
    logic [BYTE_W-1:0] vf;
    rf_wr_t            rf_wr;
    stk_op_t           stk_op;
    stk_stat_t         stk_stat;
    logic [ADDR_W-1:0] pc_next;
    logic [ADDR_W-1:0] index_next;
    logic [BYTE_W-1:0] x_after;
    logic              fault;

    assign fire          = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_cmd_reg  <= s_axis_tdata[4:0];
            in_x_reg    <= s_axis_tdata[8:5];
            in_y_reg    <= s_axis_tdata[12:9];
            in_imm_reg  <= s_axis_tdata[20:13];
            in_addr_reg <= s_axis_tdata[32:21];
            in_keys_reg <= s_axis_tdata[48:33];
        end
    end

    c8rf_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (accept),
        .rd_x  (s_axis_tdata[8:5]),
        .rd_y  (s_axis_tdata[12:9]),
        .ex_y  (in_y_reg),
        .wr_en (fire),
        .wr    (rf_wr),
        .vx    (vx),
        .vy    (vy),
        .v0    (v0),
        .vf    (vf)
    );

    c8rf_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (fire),
        .op        (stk_op),
        .push_data (pc_reg),
        .stat      (stk_stat)
    );

    c8rf_alu u_alu (
        .cmd            (cmd_t'(in_cmd_reg)),
        .x              (in_x_reg),
        .immediate      (in_imm_reg),
        .target_address (in_addr_reg),
        .key_mask       (in_keys_reg),
        .vx             (vx),
        .vy             (vy),
        .v0             (v0),
        .vf             (vf),
        .pc             (pc_reg),
        .index_value    (index_reg),
        .stk            (stk_stat),
        .wr             (rf_wr),
        .stk_op         (stk_op),
        .pc_next        (pc_next),
        .index_next     (index_next),
        .x_after        (x_after),
        .stack_fault    (fault)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= PC_RESET;
            index_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pc_reg <= cfg_wr_data;
            end
            else if (fire)
            begin
                pc_reg <= pc_next;
            end
            if (fire)
            begin
                index_reg <= index_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_pc_reg    <= pc_next;
            out_index_reg <= index_next;
            out_x_reg     <= x_after;
            out_f_reg     <= rf_wr.f_next;
            out_fault_reg <= fault;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'b0, out_fault_reg, out_f_reg, out_x_reg,
                            out_index_reg, out_pc_reg};

endmodule
